@@ rtl/core/carv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// carv_pkg
// Shared types, constants and saturation helpers of the comb/allpass reverb.
// ----------------------------------------------------------------------------
package carv_pkg;

   // transaction payload widths
   localparam int IN_W      = 16;
   localparam int OUT_W     = 12;
   localparam int CFG_W     = 12;
   localparam int CSR_IDX_W = 3;

   // default structure
   localparam int NUM_COMBS_DEF   = 4;
   localparam int NUM_ALLPASS_DEF = 2;
   localparam int MAX_DELAY_DEF   = 2048;

   // register map
   localparam int NUM_CFG     = 6;
   localparam int CFG_AP_BASE = 4;
   localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
      12'd1116, 12'd1188, 12'd1277, 12'd1356, 12'd556, 12'd441
   };

   // datapath widths
   localparam int SMP_W     = 14;
   localparam int MIX_W     = 20;
   localparam int COEF_W    = 15;
   localparam int MAC_W     = 31;
   localparam int MAC_SHIFT = 15;

   // Q15 coefficients
   localparam logic [COEF_W-1:0] DAMP_NEW = 15'd26214;
   localparam logic [COEF_W-1:0] DAMP_OLD = 15'd6554;
   localparam logic [COEF_W-1:0] FEEDBACK = 15'd27525;

   // coefficient select codes
   localparam logic [1:0] COEF_DAMP_NEW = 2'd0;
   localparam logic [1:0] COEF_DAMP_OLD = 2'd1;
   localparam logic [1:0] COEF_FEEDBACK = 2'd2;

   localparam logic signed [MIX_W-1:0] SMP_MAX = MIX_W'(8191);
   localparam logic signed [MIX_W-1:0] SMP_MIN = MIX_W'(-8192);
   localparam logic signed [MIX_W-1:0] OUT_MAX = MIX_W'(2047);
   localparam logic signed [MIX_W-1:0] OUT_MIN = MIX_W'(-2048);

   typedef struct packed {
      logic       en;
      logic       clr;
      logic [1:0] coef_sel;
   } mac_ctl_type;

   function automatic logic [SMP_W-1:0] sat_smp(input logic signed [MIX_W-1:0] v);
      logic [SMP_W-1:0] r;
      if (v > SMP_MAX) begin
         r = SMP_MAX[SMP_W-1:0];
      end else if (v < SMP_MIN) begin
         r = SMP_MIN[SMP_W-1:0];
      end else begin
         r = v[SMP_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [OUT_W-1:0] sat_out(input logic signed [MIX_W-1:0] v);
      logic [OUT_W-1:0] r;
      if (v > OUT_MAX) begin
         r = OUT_MAX[OUT_W-1:0];
      end else if (v < OUT_MIN) begin
         r = OUT_MIN[OUT_W-1:0];
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/core/carv_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// carv_if
// Valid/ready channel interfaces: sample in, sample out, register writes.
// ----------------------------------------------------------------------------
interface carv_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [carv_pkg::IN_W-1:0]    sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface carv_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [carv_pkg::OUT_W-1:0]   sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

interface carv_csr_if;
   logic                                valid;
   logic                                ready;
   logic [carv_pkg::CSR_IDX_W-1:0]      index;
   logic [carv_pkg::CFG_W-1:0]          data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/carv_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// carv_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module carv_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 2048
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/core/carv_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// carv_mac
// Shared multiply-accumulate unit for damping and feedback products.
// ----------------------------------------------------------------------------
module carv_mac (
   input  logic                                clock,
   input  carv_pkg::mac_ctl_type               ctl,
   input  logic signed [carv_pkg::SMP_W-1:0]   op_a,
   output logic signed [carv_pkg::MAC_W-1:0]   acc
);
   import carv_pkg::*;

   logic [COEF_W-1:0]        coef;
   logic signed [COEF_W:0]   coef_s;
   logic signed [MAC_W-1:0]  prod;
   logic signed [MAC_W-1:0]  acc_ff;
   logic signed [MAC_W-1:0]  acc_in;

   always_comb begin
      unique case (ctl.coef_sel)
         COEF_DAMP_NEW: coef = DAMP_NEW;
         COEF_DAMP_OLD: coef = DAMP_OLD;
         COEF_FEEDBACK: coef = FEEDBACK;
         default:       coef = '0;
      endcase
   end

   assign coef_s = $signed({1'b0, coef});
   assign prod   = op_a * coef_s;
   assign acc_in = (ctl.clr ? '0 : acc_ff) + prod;

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

@@ rtl/core/comb_allpass_reverb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comb_allpass_reverb
// Fixed-point reverberator: parallel damped feedback combs, series allpasses.
// ----------------------------------------------------------------------------
// One transaction at a time: req is ready only when idle, as the single shared
// MAC and one delay-RAM port per bank are sequenced through every comb and
// allpass; the final step waits while a previous output is still unaccepted.
// Reset: control registers return to defaults, then a clearing pass over
// max(NUM_COMBS, NUM_ALLPASS) * MAX_DELAY addresses zeroes the delay RAMs;
// req is not ready meanwhile, csr writes are taken throughout.
module comb_allpass_reverb #(
   parameter int NUM_COMBS   = carv_pkg::NUM_COMBS_DEF,
   parameter int NUM_ALLPASS = carv_pkg::NUM_ALLPASS_DEF,
   parameter int MAX_DELAY   = carv_pkg::MAX_DELAY_DEF
) (
   input  logic         clock,
   input  logic         reset,
   carv_req_if.sink     req_if,
   carv_rsp_if.source   rsp_if,
   carv_csr_if.sink     csr_if
);
   import carv_pkg::*;

   localparam int CD    = NUM_COMBS * MAX_DELAY;
   localparam int AD    = NUM_ALLPASS * MAX_DELAY;
   localparam int CLR_N = (CD > AD) ? CD : AD;
   localparam int CA_W  = $clog2(CD);
   localparam int AA_W  = $clog2(AD);
   localparam int CLR_W = $clog2(CLR_N);
   localparam int POS_W = $clog2(MAX_DELAY);
   localparam int LEN_W = $clog2(MAX_DELAY + 1);
   localparam int LW    = (LEN_W > CFG_W) ? LEN_W : CFG_W;
   localparam int CI_W  = (NUM_COMBS > 1) ? $clog2(NUM_COMBS) : 1;
   localparam int AI_W  = (NUM_ALLPASS > 1) ? $clog2(NUM_ALLPASS) : 1;

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_CLR    = 4'd0;
   localparam logic [ST_W-1:0] ST_IDLE   = 4'd1;
   localparam logic [ST_W-1:0] ST_C_RD   = 4'd2;
   localparam logic [ST_W-1:0] ST_C_MUL1 = 4'd3;
   localparam logic [ST_W-1:0] ST_C_MUL2 = 4'd4;
   localparam logic [ST_W-1:0] ST_C_FB   = 4'd5;
   localparam logic [ST_W-1:0] ST_C_WR   = 4'd6;
   localparam logic [ST_W-1:0] ST_A_RD   = 4'd7;
   localparam logic [ST_W-1:0] ST_A_CALC = 4'd8;
   localparam logic [ST_W-1:0] ST_FIN    = 4'd9;

   logic [ST_W-1:0]            state_ff, state_in;
   logic [CLR_W-1:0]           clr_cnt_ff;
   logic [CFG_W-1:0]           cfg_ff [NUM_CFG];
   logic [POS_W-1:0]           comb_pos_ff [NUM_COMBS];
   logic [POS_W-1:0]           ap_pos_ff [NUM_ALLPASS];
   logic signed [SMP_W-1:0]    damp_ff [NUM_COMBS];
   logic [CI_W-1:0]            comb_idx_ff;
   logic [AI_W-1:0]            ap_idx_ff;
   logic signed [SMP_W-1:0]    in_smp_ff;
   logic signed [MIX_W-1:0]    mix_ff;
   logic [OUT_W-1:0]           out_ff;
   logic                       out_valid_ff;

   logic                       accept;
   logic                       clearing;
   logic                       comb_last, ap_last;
   logic                       ap_phase;
   logic [POS_W-1:0]           comb_pos_cur, ap_pos_cur, pos_sel, pos_adv;
   logic signed [SMP_W-1:0]    damp_cur;
   logic [CA_W-1:0]            comb_addr;
   logic [AA_W-1:0]            ap_addr;
   logic [CFG_W-1:0]           len_reg;
   logic [LW-1:0]              len_eff, pos_next;
   logic [SMP_W-1:0]           comb_rdata, ap_rdata;
   logic signed [SMP_W-1:0]    comb_rd, mac_hi;
   logic signed [MIX_W-1:0]    ap_buf;
   logic [SMP_W-1:0]           comb_wval, ap_wval;
   logic                       comb_we, ap_we;
   logic [CA_W-1:0]            comb_waddr;
   logic [AA_W-1:0]            ap_waddr;
   logic [SMP_W-1:0]           comb_wdata, ap_wdata;
   logic signed [MAC_W-1:0]    mac_acc;
   logic signed [SMP_W-1:0]    mac_op;
   mac_ctl_type                mac_ctl;

   assign accept       = req_if.valid && req_if.ready;
   assign clearing     = (state_ff == ST_CLR);
   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.sample_out = $signed(out_ff);

   assign comb_last = (comb_idx_ff == CI_W'(NUM_COMBS - 1));
   assign ap_last   = (ap_idx_ff == AI_W'(NUM_ALLPASS - 1));
   assign ap_phase  = (state_ff == ST_A_RD) || (state_ff == ST_A_CALC);

   assign comb_pos_cur = comb_pos_ff[comb_idx_ff];
   assign ap_pos_cur   = ap_pos_ff[ap_idx_ff];
   assign damp_cur     = damp_ff[comb_idx_ff];

   assign comb_addr = CA_W'(comb_idx_ff) * CA_W'(MAX_DELAY) + CA_W'(comb_pos_cur);
   assign ap_addr   = AA_W'(ap_idx_ff) * AA_W'(MAX_DELAY) + AA_W'(ap_pos_cur);

   // index advance, shared by combs and allpasses
   always_comb begin
      if (ap_phase) begin
         len_reg = cfg_ff[CSR_IDX_W'(CFG_AP_BASE) + CSR_IDX_W'(ap_idx_ff)];
         pos_sel = ap_pos_cur;
      end else begin
         len_reg = cfg_ff[CSR_IDX_W'(comb_idx_ff)];
         pos_sel = comb_pos_cur;
      end
      if (len_reg == '0) begin
         len_eff = LW'(1);
      end else if (LW'(len_reg) > LW'(MAX_DELAY)) begin
         len_eff = LW'(MAX_DELAY);
      end else begin
         len_eff = LW'(len_reg);
      end
      pos_next = LW'(pos_sel) + LW'(1);
      pos_adv  = (pos_next >= len_eff) ? '0 : pos_next[POS_W-1:0];
   end

   // datapath
   assign comb_rd   = $signed(comb_rdata);
   assign mac_hi    = mac_acc[MAC_SHIFT+SMP_W-1:MAC_SHIFT];
   assign comb_wval = sat_smp(MIX_W'(in_smp_ff) + MIX_W'(mac_hi));
   assign ap_buf    = MIX_W'($signed(ap_rdata));
   assign ap_wval   = sat_smp(mix_ff + (ap_buf >>> 1));

   // RAM write ports, muxed with the clearing pass
   always_comb begin
      if (clearing) begin
         comb_we    = ({1'b0, clr_cnt_ff} < (CLR_W+1)'(CD));
         comb_waddr = clr_cnt_ff[CA_W-1:0];
         comb_wdata = '0;
         ap_we      = ({1'b0, clr_cnt_ff} < (CLR_W+1)'(AD));
         ap_waddr   = clr_cnt_ff[AA_W-1:0];
         ap_wdata   = '0;
      end else begin
         comb_we    = (state_ff == ST_C_WR);
         comb_waddr = comb_addr;
         comb_wdata = comb_wval;
         ap_we      = (state_ff == ST_A_CALC);
         ap_waddr   = ap_addr;
         ap_wdata   = ap_wval;
      end
   end

   // sequencer
   always_comb begin
      state_in         = state_ff;
      mac_ctl.en       = 1'b0;
      mac_ctl.clr      = 1'b0;
      mac_ctl.coef_sel = COEF_DAMP_NEW;
      mac_op           = comb_rd;
      unique case (state_ff)
         ST_CLR: begin
            if (clr_cnt_ff == CLR_W'(CLR_N - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_C_RD;
         end
         ST_C_RD: begin
            state_in = ST_C_MUL1;
         end
         ST_C_MUL1: begin
            mac_ctl.en  = 1'b1;
            mac_ctl.clr = 1'b1;
            state_in    = ST_C_MUL2;
         end
         ST_C_MUL2: begin
            mac_ctl.en       = 1'b1;
            mac_ctl.coef_sel = COEF_DAMP_OLD;
            mac_op           = damp_cur;
            state_in         = ST_C_FB;
         end
         ST_C_FB: begin
            mac_ctl.en       = 1'b1;
            mac_ctl.clr      = 1'b1;
            mac_ctl.coef_sel = COEF_FEEDBACK;
            mac_op           = mac_hi;
            state_in         = ST_C_WR;
         end
         ST_C_WR: begin
            state_in = comb_last ? ST_A_RD : ST_C_RD;
         end
         ST_A_RD: begin
            state_in = ST_A_CALC;
         end
         ST_A_CALC: begin
            state_in = ap_last ? ST_FIN : ST_A_RD;
         end
         ST_FIN: begin
            if (!out_valid_ff || rsp_if.ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_cnt_ff   <= '0;
         comb_idx_ff  <= '0;
         ap_idx_ff    <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CFG; i++) cfg_ff[i] <= CFG_RESET[i];
         for (int i = 0; i < NUM_COMBS; i++) begin
            comb_pos_ff[i] <= '0;
            damp_ff[i]     <= '0;
         end
         for (int i = 0; i < NUM_ALLPASS; i++) ap_pos_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (clearing) clr_cnt_ff <= clr_cnt_ff + CLR_W'(1);
         if (csr_if.valid && csr_if.ready &&
             ({1'b0, csr_if.index} < (CSR_IDX_W+1)'(NUM_CFG))) begin
            cfg_ff[csr_if.index] <= csr_if.data;
         end
         if (state_ff == ST_C_FB) damp_ff[comb_idx_ff] <= mac_hi;
         if (state_ff == ST_C_WR) begin
            comb_pos_ff[comb_idx_ff] <= pos_adv;
            comb_idx_ff <= comb_last ? '0 : comb_idx_ff + CI_W'(1);
         end
         if (state_ff == ST_A_CALC) begin
            ap_pos_ff[ap_idx_ff] <= pos_adv;
            ap_idx_ff <= ap_last ? '0 : ap_idx_ff + AI_W'(1);
         end
         if ((state_ff == ST_FIN) && (!out_valid_ff || rsp_if.ready)) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.valid && rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_smp_ff <= req_if.sample_in[IN_W-1:IN_W-SMP_W];
         mix_ff    <= '0;
      end
      if (state_ff == ST_C_MUL1) mix_ff <= mix_ff + MIX_W'(comb_rd);
      if ((state_ff == ST_C_WR) && comb_last) mix_ff <= mix_ff >>> 2;
      if (state_ff == ST_A_CALC) mix_ff <= ap_buf - mix_ff;
      if ((state_ff == ST_FIN) && (!out_valid_ff || rsp_if.ready)) begin
         out_ff <= sat_out(mix_ff >>> 1);
      end
   end

   carv_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (mac_op),
      .acc   (mac_acc)
   );

   carv_ram #(.WIDTH(SMP_W), .DEPTH(CD)) u_comb_ram (
      .clock   (clock),
      .wr_en   (comb_we),
      .wr_addr (comb_waddr),
      .wr_data (comb_wdata),
      .rd_addr (comb_addr),
      .rd_data (comb_rdata)
   );

   carv_ram #(.WIDTH(SMP_W), .DEPTH(AD)) u_ap_ram (
      .clock   (clock),
      .wr_en   (ap_we),
      .wr_addr (ap_waddr),
      .wr_data (ap_wdata),
      .rd_addr (ap_addr),
      .rd_data (ap_rdata)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_if.ready)
      else $error("req ready right after accepting a transaction");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(state_ff == ST_FIN))
      else $error("rsp valid raised outside the final step");

   a_comb_pos_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_C_WR) |-> ({1'b0, comb_pos_cur} < (POS_W+1)'(MAX_DELAY)))
      else $error("comb position beyond delay store");
`endif

endmodule

@@ test/tb_comb_allpass_reverb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_comb_allpass_reverb
// Self-checking bench for the comb/allpass reverberator. Samples stream in
// through a queue-fed driver. A bit-accurate predictor keeps its own delay
// lines, damping stores, positions and length registers, and queues the
// expected output sample for each accepted transaction. A monitor checks
// every output against that queue. The run has several length settings:
// zero, one, maximum, over maximum, shrink below position, random short
// lengths. Writes to indexes past the register map are also covered.
// ----------------------------------------------------------------------------
module tb_comb_allpass_reverb;
   import carv_pkg::*;

   localparam int     N_COMB       = NUM_COMBS_DEF;
   localparam int     N_AP         = NUM_ALLPASS_DEF;
   localparam int     MAX_D        = MAX_DELAY_DEF;
   localparam longint Q15_DAMP_NEW = 26214;
   localparam longint Q15_DAMP_OLD = 6554;
   localparam longint Q15_FEEDBACK = 27525;
   localparam int     TAIL_CYCLES  = 40;
   localparam int     CYCLE_LIMIT  = 400000;

   typedef enum logic [CSR_IDX_W-1:0] {
      COMB_LEN_0, COMB_LEN_1, COMB_LEN_2, COMB_LEN_3,
      AP_LEN_0, AP_LEN_1, IDX_SPARE_6, IDX_SPARE_7
   } csr_index_type;

   logic clock;
   logic reset;

   carv_req_if req_if ();
   carv_rsp_if rsp_if ();
   carv_csr_if csr_if ();

   comb_allpass_reverb DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // predictor state
   logic [CFG_W-1:0] len_reg [NUM_CFG];
   longint           comb_mem [N_COMB][MAX_D];
   longint           comb_damp [N_COMB];
   int unsigned      comb_pos [N_COMB];
   longint           ap_mem [N_AP][MAX_D];
   int unsigned      ap_pos [N_AP];

   logic signed [IN_W-1:0]  pending_samples [$];
   logic signed [OUT_W-1:0] expected_samples [$];

   int mismatches  = 0;
   int cycle_count = 0;
   int send_gap    = 0;
   int stall_left  = 0;
   bit idle_on     = 1'b1;

   always #4 clock = ~clock;

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      if (v > hi) begin
         return hi;
      end
      if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   function automatic int unsigned next_pos(input int unsigned p, input logic [CFG_W-1:0] r);
      int unsigned span;
      span = (r == 0) ? 1 : ((r > MAX_D) ? MAX_D : int'(r));
      return (p + 1 >= span) ? 0 : p + 1;
   endfunction

   function automatic logic signed [OUT_W-1:0] reverb_predict(input logic signed [IN_W-1:0] smp);
      longint      dry;
      longint      mix;
      longint      y;
      longint      fb;
      int unsigned p;
      dry = longint'(smp) >>> 2;
      mix = 0;
      for (int c = 0; c < N_COMB; c++) begin
         p = comb_pos[c] % MAX_D;
         y = comb_mem[c][p];
         mix += y;
         comb_damp[c] = (y * Q15_DAMP_NEW + comb_damp[c] * Q15_DAMP_OLD) >>> 15;
         fb = (comb_damp[c] * Q15_FEEDBACK) >>> 15;
         comb_mem[c][p] = clip(dry + fb, -8192, 8191);
         comb_pos[c] = next_pos(p, len_reg[c]);
      end
      mix = mix >>> 2;
      for (int a = 0; a < N_AP; a++) begin
         p = ap_pos[a] % MAX_D;
         y = ap_mem[a][p] - mix;
         ap_mem[a][p] = clip(mix + (ap_mem[a][p] >>> 1), -8192, 8191);
         ap_pos[a] = next_pos(p, len_reg[CFG_AP_BASE + a]);
         mix = y;
      end
      return OUT_W'(clip(mix >>> 1, -2048, 2047));
   endfunction

   function automatic logic signed [IN_W-1:0] pick_sample();
      case ($urandom_range(0, 9)) inside
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         [2:3]: return IN_W'(int'($urandom_range(0, 1023)) - 512);
         default: return IN_W'($urandom);
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_length();
      if ($urandom_range(0, 7) == 0) begin
         return CFG_W'($urandom_range(0, 4095));
      end
      return CFG_W'($urandom_range(1, 64));
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("mismatch at cycle %0d: %s got %0d expected %0d",
               cycle_count, what, got, want);
   endtask

   // leaves valid high; csr_release drops it after a burst
   task automatic csr_write(input csr_index_type idx, input logic [CFG_W-1:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      if (int'(idx) < NUM_CFG) begin
         len_reg[idx] = val;
      end
   endtask

   task automatic csr_release();
      csr_if.valid <= 1'b0;
   endtask

   task automatic load_lengths(input logic [CFG_W-1:0] c0, input logic [CFG_W-1:0] c1,
                               input logic [CFG_W-1:0] c2, input logic [CFG_W-1:0] c3,
                               input logic [CFG_W-1:0] a0, input logic [CFG_W-1:0] a1);
      csr_write(COMB_LEN_0, c0);
      csr_write(COMB_LEN_1, c1);
      csr_write(COMB_LEN_2, c2);
      csr_write(COMB_LEN_3, c3);
      csr_write(AP_LEN_0, a0);
      csr_write(AP_LEN_1, a1);
      csr_release();
   endtask

   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_if.valid || expected_samples.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_samples.push_back(reverb_predict(req_if.sample_in));
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               req_if.valid <= 1'b0;
               send_gap--;
            end else if (pending_samples.size() != 0) begin
               req_if.valid     <= 1'b1;
               req_if.sample_in <= pending_samples.pop_front();
               if (idle_on && $urandom_range(0, 7) == 0) begin
                  send_gap = $urandom_range(1, 5);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("unexpected transaction, sample_out", rsp_if.sample_out, 0);
            end else if (rsp_if.sample_out !== expected_samples[0]) begin
               report_mismatch("sample_out", rsp_if.sample_out, expected_samples.pop_front());
            end else begin
               void'(expected_samples.pop_front());
            end
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) begin
               stall_left = $urandom_range(1, 5);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.sample_in = '0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = COMB_LEN_0;
      csr_if.data      = '0;
      for (int i = 0; i < NUM_CFG; i++) begin
         len_reg[i] = CFG_RESET[i];
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset lengths, extremes
      pending_samples = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'shFFFE,
                          16'sh0003, 16'shFFFC, 16'sh5555, 16'shAAAA, 16'sh0004, 16'shFFFB};
      wait_drained();

      // zero lengths and unit lengths: immediate feedback, saturation
      csr_write(IDX_SPARE_6, 12'hABC);
      csr_write(IDX_SPARE_7, 12'h555);
      load_lengths(12'd0, 12'd1, 12'd2, 12'd3, 12'd0, 12'd1);
      pending_samples = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
                          16'sh8000, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh7FFF, 16'sh8000,
                          16'sh0001};
      wait_drained();

      // top of range and beyond
      load_lengths(12'd4095, 12'd2048, 12'd2047, 12'd2049, 12'd4095, 12'd2048);
      repeat (150) pending_samples.push_back(pick_sample());
      wait_drained();

      // shrink below the current positions
      load_lengths(12'd5, 12'd7, 12'd11, 12'd13, 12'd3, 12'd9);
      repeat (250) pending_samples.push_back(pick_sample());
      wait_drained();

      for (int k = 0; k < 3; k++) begin
         load_lengths(pick_length(), pick_length(), pick_length(),
                      pick_length(), pick_length(), pick_length());
         repeat (250) pending_samples.push_back(pick_sample());
         wait_drained();
      end

      // back-to-back, no idling
      idle_on = 1'b0;
      load_lengths(12'd16, 12'd23, 12'd31, 12'd37, 12'd8, 12'd12);
      repeat (400) pending_samples.push_back(pick_sample());
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ comb_allpass_reverb.f @@
rtl/core/carv_pkg.sv
rtl/core/carv_if.sv
rtl/core/carv_ram.sv
rtl/core/carv_mac.sv
rtl/core/comb_allpass_reverb.sv
test/tb_comb_allpass_reverb.sv
